// ----- hdl/isoc_credit_scheduler_macros.svh -----
// Assertion macros for the isochronous credit scheduler.
`ifndef ISOC_CREDIT_SCHEDULER_MACROS_SVH
`define ISOC_CREDIT_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define ISOC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISOC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISOC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/isoc_pkg.sv -----
// Types and constants shared by the isochronous credit scheduler modules.
package isoc_pkg;

    localparam int PKT_W     = 8;
    localparam int ELAPSED_W = 16;
    localparam int CREDIT_W  = 20;
    localparam int UNITS_W   = 16;
    localparam int FRAME_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int KIND_W    = 2;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 20'hFFFFF;
    localparam logic [UNITS_W-1:0]  UNITS_MAX   = 16'hFFFF;
    localparam logic [CFG_W-1:0]    CEILING_RST = 16'd16;
    localparam logic [CFG_W-1:0]    THRESH_RST  = 16'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_ENQUEUE = 2'd1,
        MODE_UNITS   = 2'd2
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RELEASE   = 2'd0,
        KIND_TICK_DONE = 2'd1,
        KIND_ACCEPT    = 2'd2,
        KIND_REJECT    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION_IN    = 2'd0,
        CFG_CREDIT_CEILING  = 2'd1,
        CFG_BUFFER_THRESH   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec_item;
        logic tick;
        logic read_head;
        logic release_head;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hold_buffering;
        logic              loop_ok;
        logic              release_ok;
        logic              out_free;
    } status_t;

endpackage

// ----- hdl/isoc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module isoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/isoc_ctrl.sv -----
// Sequencer for the isochronous credit scheduler: steps each item through the datapath.
`include "isoc_credit_scheduler_macros.svh"
module isoc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  isoc_pkg::status_t status,
    output isoc_pkg::cmd_t    cmd
);

    isoc_pkg::state_t state_reg;
    isoc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isoc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            isoc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = isoc_pkg::ST_DISPATCH;
                end
            end
            isoc_pkg::ST_DISPATCH:
            begin
                unique case (isoc_pkg::mode_t'(status.mode))
                    isoc_pkg::MODE_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        state_next = status.hold_buffering ? isoc_pkg::ST_DONE
                                                           : isoc_pkg::ST_READ;
                    end
                    isoc_pkg::MODE_ENQUEUE, isoc_pkg::MODE_UNITS:
                    begin
                        if (status.out_free)
                        begin
                            cmd.exec_item = 1'b1;
                            state_next    = isoc_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = isoc_pkg::ST_IDLE;
                    end
                endcase
            end
            isoc_pkg::ST_READ:
            begin
                if (status.loop_ok)
                begin
                    cmd.read_head = 1'b1;
                    state_next    = isoc_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = isoc_pkg::ST_DONE;
                end
            end
            isoc_pkg::ST_CHECK:
            begin
                if (!status.release_ok)
                begin
                    state_next = isoc_pkg::ST_DONE;
                end
                else if (status.out_free)
                begin
                    cmd.release_head = 1'b1;
                    state_next       = isoc_pkg::ST_READ;
                end
            end
            isoc_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = isoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isoc_pkg::ST_IDLE;
            end
        endcase
    end

    `ISOC_ASSERT(a_check_after_read, clk, rst_n, (state_reg == isoc_pkg::ST_CHECK) |-> ($past(state_reg) == isoc_pkg::ST_READ || $past(state_reg) == isoc_pkg::ST_CHECK), "head check without a preceding read")
    `ISOC_ASSERT(a_load_only_idle, clk, rst_n, cmd.load_item |=> (state_reg == isoc_pkg::ST_DISPATCH), "item load did not start dispatch")

endmodule

// ----- hdl/isoc_dp.sv -----
// Datapath of the isochronous credit scheduler: queue, credit, units, frame and result register.
`include "isoc_credit_scheduler_macros.svh"
module isoc_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [isoc_pkg::MODE_W-1:0]         mode,
    input  logic [isoc_pkg::ELAPSED_W-1:0]      elapsed_ms,
    input  logic [isoc_pkg::PKT_W-1:0]          packets,
    input  logic                                cfg_we,
    input  logic [isoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isoc_pkg::CFG_W-1:0]          cfg_wdata,
    input  isoc_pkg::cmd_t                      cmd,
    output isoc_pkg::status_t                   status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [isoc_pkg::KIND_W-1:0]         kind,
    output logic [isoc_pkg::PKT_W-1:0]          released_packets,
    output logic [isoc_pkg::FRAME_W-1:0]        frame_stamp,
    output logic [isoc_pkg::CREDIT_W-1:0]       credit_left,
    output logic                                queue_nonempty,
    output logic                                last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CW    = isoc_pkg::CREDIT_W;
    localparam int UW    = isoc_pkg::UNITS_W;
    localparam int FW    = isoc_pkg::FRAME_W;
    localparam int PW    = isoc_pkg::PKT_W;

    // configuration
    logic                       dir_in_reg, dir_in_next;
    logic [isoc_pkg::CFG_W-1:0] ceiling_reg, ceiling_next;
    logic [isoc_pkg::CFG_W-1:0] thresh_reg, thresh_next;

    // latched item
    logic [isoc_pkg::MODE_W-1:0]    mode_reg;
    logic [isoc_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [PW-1:0]                  pkt_reg;

    // scheduler state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    credit_reg, credit_next;
    logic [UW-1:0]    units_reg, units_next;
    logic             buffering_reg, buffering_next;
    logic [FW-1:0]    frame_reg, frame_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [isoc_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [PW-1:0]               rel_reg, rel_next;
    logic [FW-1:0]               sf_reg, sf_next;
    logic [CW-1:0]               credit_out_reg, credit_out_next;
    logic                        nonempty_reg, nonempty_next;
    logic                        last_reg, last_next;

    logic             emit;
    logic             full;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] head_inc;
    logic             ram_we;
    logic [PW-1:0]    head_pkt;
    logic [UW:0]      units_sum;
    logic [CW:0]      credit_sum;
    logic [CW-1:0]    out_tick_credit;
    logic [CW-1:0]    in_tick_credit;
    logic [CW-1:0]    pkt_ext;
    logic [UW-1:0]    pkt_ext_u;
    logic [CW:0]      credit_plus1;
    logic             out_free;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ram_we   = cmd.exec_item && (mode_reg == isoc_pkg::MODE_ENQUEUE) && !full;

    isoc_ram #(
        .WIDTH (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_idx),
        .wdata (pkt_reg),
        .re    (cmd.read_head),
        .raddr (head_reg),
        .rdata (head_pkt)
    );

    assign units_sum       = (UW+1)'(units_reg) + (UW+1)'(pkt_reg);
    assign credit_sum      = (CW+1)'(credit_reg) + (CW+1)'(elapsed_reg);
    assign out_tick_credit = (credit_sum > (CW+1)'(ceiling_reg))
                             ? CW'(ceiling_reg) : CW'(credit_sum);
    assign in_tick_credit  = credit_sum[CW] ? isoc_pkg::CREDIT_MAX : CW'(credit_sum);
    assign pkt_ext         = CW'(head_pkt);
    assign pkt_ext_u       = UW'(head_pkt);
    assign credit_plus1    = (CW+1)'(credit_reg) + 1'b1;
    assign out_free        = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.mode           = mode_reg;
        status.hold_buffering = dir_in_reg && buffering_reg;
        status.loop_ok        = (count_reg != '0) && (dir_in_reg || (credit_reg != '0));
        status.out_free       = out_free;
        if (dir_in_reg)
        begin
            status.release_ok = (credit_reg >= pkt_ext) && (units_reg >= pkt_ext_u);
        end
        else
        begin
            status.release_ok = (credit_plus1 >= (CW+1)'(head_pkt));
        end
    end

    always_comb
    begin
        dir_in_next    = dir_in_reg;
        ceiling_next   = ceiling_reg;
        thresh_next    = thresh_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        credit_next    = credit_reg;
        units_next     = units_reg;
        buffering_next = buffering_reg;
        frame_next     = frame_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        rel_next       = '0;
        sf_next        = '0;
        last_next      = 1'b0;

        if (cfg_we)
        begin
            unique case (isoc_pkg::cfg_idx_t'(cfg_index))
                isoc_pkg::CFG_DIRECTION_IN:   dir_in_next  = cfg_wdata[0];
                isoc_pkg::CFG_CREDIT_CEILING: ceiling_next = cfg_wdata;
                isoc_pkg::CFG_BUFFER_THRESH:  thresh_next  = cfg_wdata;
                default:                      dir_in_next  = dir_in_reg;
            endcase
        end

        if (cmd.exec_item)
        begin
            emit      = 1'b1;
            last_next = 1'b1;
            if (mode_reg == isoc_pkg::MODE_ENQUEUE)
            begin
                if (full)
                begin
                    kind_next = isoc_pkg::KIND_REJECT;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    kind_next  = isoc_pkg::KIND_ACCEPT;
                end
            end
            else if (units_sum[UW])
            begin
                units_next = isoc_pkg::UNITS_MAX;
                kind_next  = isoc_pkg::KIND_REJECT;
            end
            else
            begin
                units_next = UW'(units_sum);
                kind_next  = isoc_pkg::KIND_ACCEPT;
            end
        end

        if (cmd.tick)
        begin
            if (!dir_in_reg)
            begin
                credit_next = out_tick_credit;
            end
            else if (buffering_reg)
            begin
                if (units_reg >= thresh_reg)
                begin
                    buffering_next = 1'b0;
                    credit_next    = '0;
                    frame_next     = '0;
                end
            end
            else
            begin
                credit_next = in_tick_credit;
            end
        end

        if (cmd.release_head)
        begin
            emit       = 1'b1;
            kind_next  = isoc_pkg::KIND_RELEASE;
            rel_next   = head_pkt;
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            if (dir_in_reg)
            begin
                credit_next = credit_reg - pkt_ext;
                units_next  = units_reg - pkt_ext_u;
                frame_next  = frame_reg + FW'(head_pkt);
                sf_next     = frame_reg;
            end
            else
            begin
                credit_next = (credit_reg > pkt_ext) ? credit_reg - pkt_ext : '0;
            end
        end

        if (cmd.done)
        begin
            emit      = 1'b1;
            kind_next = isoc_pkg::KIND_TICK_DONE;
            last_next = 1'b1;
        end

        credit_out_next = credit_next;
        nonempty_next   = (count_next != '0);
        out_valid_next  = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_in_reg    <= 1'b0;
            ceiling_reg   <= isoc_pkg::CEILING_RST;
            thresh_reg    <= isoc_pkg::THRESH_RST;
            head_reg      <= '0;
            count_reg     <= '0;
            credit_reg    <= '0;
            units_reg     <= '0;
            buffering_reg <= 1'b1;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_in_reg    <= dir_in_next;
            ceiling_reg   <= ceiling_next;
            thresh_reg    <= thresh_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            credit_reg    <= credit_next;
            units_reg     <= units_next;
            buffering_reg <= buffering_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg    <= mode;
            elapsed_reg <= elapsed_ms;
            pkt_reg     <= packets;
        end
        if (emit)
        begin
            kind_reg       <= kind_next;
            rel_reg        <= rel_next;
            sf_reg         <= sf_next;
            credit_out_reg <= credit_out_next;
            nonempty_reg   <= nonempty_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign released_packets = rel_reg;
    assign frame_stamp      = sf_reg;
    assign credit_left      = credit_out_reg;
    assign queue_nonempty   = nonempty_reg;
    assign last             = last_reg;

    `ISOC_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg <= CNT_W'(QUEUE_DEPTH)), "count beyond depth")
    `ISOC_ASSERT(a_emit_when_free, clk, rst_n, emit |-> out_free, "result written over a waiting result")
    `ISOC_ASSERT(a_release_pops, clk, rst_n, cmd.release_head |=> (count_reg == $past(count_reg) - 1'b1), "no pop")

endmodule

// ----- hdl/isoc_credit_scheduler.sv -----
// Top level of the isochronous credit scheduler.
// Input channel (in_valid/in_stall) carries one item: mode, elapsed_ms, packets.
// Mode tick adds credit and releases head transfers outside the IN buffering phase;
// enqueue pushes a transfer; units adds buffered units. Output channel (out_valid/out_stall)
// carries the results: one per enqueue or units item, and for a tick one result per
// released transfer followed by a tick-done result; last marks the final one.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Items are handled one at a time. An enqueue or units item moves from idle to dispatch,
// loads its result there once the output register is free and returns to idle, where
// the next item is taken. A tick passes through dispatch, then read and check for each
// release and a final read, and loads its tick-done result in the done state; a failed
// head check also goes to done, and in the IN buffering phase dispatch goes straight to done.
// Each release reads the queue memory and then checks the head, so the read port sets the pace.
// The output register frees the engine as soon as a result is loaded; while
// the receiver stalls, a further result waits and in_stall stays high.
// Reset empties the queue, clears credit, units and frame, enters the IN
// buffering phase and loads the register defaults; no clearing pass is needed.
module isoc_credit_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [isoc_pkg::MODE_W-1:0]        mode,
    input  logic [isoc_pkg::ELAPSED_W-1:0]     elapsed_ms,
    input  logic [isoc_pkg::PKT_W-1:0]         packets,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [isoc_pkg::KIND_W-1:0]        kind,
    output logic [isoc_pkg::PKT_W-1:0]         released_packets,
    output logic [isoc_pkg::FRAME_W-1:0]       frame_stamp,
    output logic [isoc_pkg::CREDIT_W-1:0]      credit_left,
    output logic                               queue_nonempty,
    output logic                               last,
    input  logic                               cfg_we,
    input  logic [isoc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [isoc_pkg::CFG_W-1:0]         cfg_wdata
);

    isoc_pkg::cmd_t    cmd;
    isoc_pkg::status_t status;

    isoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    isoc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .mode             (mode),
        .elapsed_ms       (elapsed_ms),
        .packets          (packets),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .status           (status),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .kind             (kind),
        .released_packets (released_packets),
        .frame_stamp      (frame_stamp),
        .credit_left      (credit_left),
        .queue_nonempty   (queue_nonempty),
        .last             (last)
    );

endmodule
